// ----- design/assert_macros.svh -----
// Assertion macros shared by the collision resolver RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CPCR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define CPCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define CPCR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CPCR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/cpcr_pkg.sv -----
// Package of the circle pair collision resolver: pipeline payload types,
// constants and the saturation helper. No dependencies.
`default_nettype none
package cpcr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int FORCE_DEF     = 100;
    localparam int IN_W          = 192;
    localparam int OUT_W         = 256;
    localparam int SQRT_STEPS    = 32;

    // Payload carried through the front, root, setup, divider and back stages.
    typedef struct packed {
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic [31:0]        rsum;
        logic               sx;
        logic               sy;
        logic [31:0]        adx;
        logic [31:0]        ady;
        logic               hit;
        logic [63:0]        rem;
        logic [63:0]        res;
        logic [31:0]        dlen;
        logic [31:0]        depth;
        logic               dz;
    } t_pipe;

    typedef struct packed {
        logic        hit;
        logic [31:0] nfx;
        logic [31:0] nfy;
        logic [31:0] nsx;
        logic [31:0] nsy;
        logic [31:0] ffx;
        logic [31:0] ffy;
        logic [31:0] sfx;
        logic [31:0] sfy;
    } t_result;

    function automatic logic [31:0] sat35(input logic signed [34:0] v);
        logic [31:0] r;
        if (v > 35'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -35'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- design/cpcr_front.sv -----
// Front stages: differences, squares and the exact overlap test.
// Depends on cpcr_pkg.
`default_nettype none
module cpcr_front (
    input  wire logic                      i_clk,
    input  wire logic [2:0]                i_load,
    input  wire logic [cpcr_pkg::IN_W-1:0] i_tdata,
    output cpcr_pkg::t_pipe                o_q
);
    import cpcr_pkg::*;

    t_pipe r_s0, n_s0, r_s1, r_s2, n_s2;
    logic [63:0] r_dx2, r_dy2, r_rs2;
    logic        r_small;
    logic signed [32:0] dx, dy;

    always_comb begin
        n_s0 = '0;
        n_s0.x1 = i_tdata[31:0];
        n_s0.y1 = i_tdata[63:32];
        n_s0.x2 = i_tdata[126:95];
        n_s0.y2 = i_tdata[158:127];
        dx = {n_s0.x2[31], n_s0.x2} - {n_s0.x1[31], n_s0.x1};
        dy = {n_s0.y2[31], n_s0.y2} - {n_s0.y1[31], n_s0.y1};
        n_s0.sx   = dx[32];
        n_s0.sy   = dy[32];
        n_s0.adx  = dx[32] ? 32'(-dx) : dx[31:0];
        n_s0.ady  = dy[32] ? 32'(-dy) : dy[31:0];
        n_s0.rsum = {1'b0, i_tdata[94:64]} + {1'b0, i_tdata[189:159]};
    end

    always_comb begin
        n_s2     = r_s1;
        n_s2.hit = r_small && (r_dx2 < (r_rs2 - r_dy2));
        n_s2.rem = r_dx2 + r_dy2;
        n_s2.res = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_s0 <= n_s0;
        end
        if (i_load[1]) begin
            r_s1    <= r_s0;
            r_dx2   <= 64'(r_s0.adx) * 64'(r_s0.adx);
            r_dy2   <= 64'(r_s0.ady) * 64'(r_s0.ady);
            r_rs2   <= 64'(r_s0.rsum) * 64'(r_s0.rsum);
            r_small <= (r_s0.adx < r_s0.rsum) && (r_s0.ady < r_s0.rsum);
        end
        if (i_load[2]) begin
            r_s2 <= n_s2;
        end
    end

    assign o_q = r_s2;
endmodule
`default_nettype wire

// ----- design/cpcr_sqrt_step.sv -----
// One iteration of the digit-by-digit integer square root, registered.
// Depends on cpcr_pkg.
`default_nettype none
module cpcr_sqrt_step #(
    parameter int STEP = 0
) (
    input  wire logic     i_clk,
    input  wire logic     i_load,
    input  cpcr_pkg::t_pipe i_d,
    output cpcr_pkg::t_pipe o_q
);
    import cpcr_pkg::*;

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    t_pipe r_q, n_q;
    logic [63:0] trial;

    always_comb begin
        n_q   = i_d;
        trial = i_d.res + BIT;
        if (i_d.rem >= trial) begin
            n_q.rem = i_d.rem - trial;
            n_q.res = (i_d.res >> 1) + BIT;
        end else begin
            n_q.res = i_d.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

// ----- design/cpcr_div_step.sv -----
// One quotient bit of the restoring divider, both axes side by side.
// Depends on cpcr_pkg.
`default_nettype none
module cpcr_div_step #(
    parameter int FRAC_BITS = 16,
    parameter int STEP      = 0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_load,
    input  cpcr_pkg::t_pipe           i_d,
    input  wire logic [FRAC_BITS+32:0] i_remx,
    input  wire logic [FRAC_BITS+32:0] i_remy,
    input  wire logic [FRAC_BITS:0]   i_qx,
    input  wire logic [FRAC_BITS:0]   i_qy,
    output cpcr_pkg::t_pipe           o_q,
    output logic [FRAC_BITS+32:0]     o_remx,
    output logic [FRAC_BITS+32:0]     o_remy,
    output logic [FRAC_BITS:0]        o_qx,
    output logic [FRAC_BITS:0]        o_qy
);
    import cpcr_pkg::*;

    localparam int W_N = FRAC_BITS + 33;
    localparam int SH  = FRAC_BITS - STEP;

    t_pipe r_q;
    logic [W_N-1:0] r_remx, r_remy, div_sh;
    logic [FRAC_BITS:0] r_qx, r_qy;

    assign div_sh = W_N'(i_d.dlen) << SH;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= i_d;
            if (i_remx >= div_sh) begin
                r_remx <= i_remx - div_sh;
                r_qx   <= i_qx | ((FRAC_BITS + 1)'(1) << SH);
            end else begin
                r_remx <= i_remx;
                r_qx   <= i_qx;
            end
            if (i_remy >= div_sh) begin
                r_remy <= i_remy - div_sh;
                r_qy   <= i_qy | ((FRAC_BITS + 1)'(1) << SH);
            end else begin
                r_remy <= i_remy;
                r_qy   <= i_qy;
            end
        end
    end

    assign o_q    = r_q;
    assign o_remx = r_remx;
    assign o_remy = r_remy;
    assign o_qx   = r_qx;
    assign o_qy   = r_qy;
endmodule
`default_nettype wire

// ----- design/cpcr_back.sv -----
// Back stages: force and push products, rounding, signed offsets and
// saturated result. Depends on cpcr_pkg.
`default_nettype none
module cpcr_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic [2:0]         i_load,
    input  cpcr_pkg::t_pipe         i_d,
    input  wire logic [FRAC_BITS:0] i_qx,
    input  wire logic [FRAC_BITS:0] i_qy,
    input  wire logic [30:0]        i_force,
    output cpcr_pkg::t_result       o_res
);
    import cpcr_pkg::*;

    localparam int PF_W = FRAC_BITS + 32;
    localparam int PP_W = FRAC_BITS + 33;
    localparam logic [PF_W:0] HALF_F = (PF_W + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [PP_W:0] HALF_P = (PP_W + 1)'(1) << FRAC_BITS;

    t_pipe r_a, r_b;
    logic [PF_W-1:0] r_pfx, r_pfy;
    logic [PP_W-1:0] r_ppx, r_ppy;
    logic [FRAC_BITS:0] magx, magy;
    logic [PF_W:0] sfx, sfy;
    logic [PP_W:0] spx, spy;
    logic [30:0] fmx, fmy;
    logic [31:0] pmx, pmy;
    logic signed [33:0] r_px, r_py;
    logic signed [32:0] r_fx, r_fy;
    t_result r_res;

    assign magx = i_d.dz ? '0 : i_qx;
    assign magy = i_d.dz ? '0 : i_qy;

    assign sfx = (PF_W + 1)'(r_pfx) + HALF_F;
    assign sfy = (PF_W + 1)'(r_pfy) + HALF_F;
    assign spx = (PP_W + 1)'(r_ppx) + HALF_P;
    assign spy = (PP_W + 1)'(r_ppy) + HALF_P;
    assign fmx = r_a.hit ? 31'(sfx >> FRAC_BITS) : '0;
    assign fmy = r_a.hit ? 31'(sfy >> FRAC_BITS) : '0;
    assign pmx = r_a.hit ? 32'(spx >> (FRAC_BITS + 1)) : '0;
    assign pmy = r_a.hit ? 32'(spy >> (FRAC_BITS + 1)) : '0;

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_a   <= i_d;
            r_pfx <= PF_W'(magx) * PF_W'(i_force);
            r_pfy <= PF_W'(magy) * PF_W'(i_force);
            r_ppx <= PP_W'(magx) * PP_W'(i_d.depth);
            r_ppy <= PP_W'(magy) * PP_W'(i_d.depth);
        end
        if (i_load[1]) begin
            r_b  <= r_a;
            r_px <= r_a.sx ? -$signed({2'b00, pmx}) : $signed({2'b00, pmx});
            r_py <= r_a.sy ? -$signed({2'b00, pmy}) : $signed({2'b00, pmy});
            r_fx <= r_a.sx ? -$signed({2'b00, fmx}) : $signed({2'b00, fmx});
            r_fy <= r_a.sy ? -$signed({2'b00, fmy}) : $signed({2'b00, fmy});
        end
        if (i_load[2]) begin
            r_res.hit <= r_b.hit;
            r_res.nfx <= sat35(35'(r_b.x1) - 35'(r_px));
            r_res.nfy <= sat35(35'(r_b.y1) - 35'(r_py));
            r_res.nsx <= sat35(35'(r_b.x2) + 35'(r_px));
            r_res.nsy <= sat35(35'(r_b.y2) + 35'(r_py));
            r_res.ffx <= 32'(-r_fx);
            r_res.ffy <= 32'(-r_fy);
            r_res.sfx <= r_fx[31:0];
            r_res.sfy <= r_fy[31:0];
        end
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

// ----- design/circle_pair_collision_resolve_unit.sv -----
// Circle pair collision resolver, top level.
// Channels: s_axis carries one circle pair per request in s_axis_tdata;
// m_axis returns one result per request, the overlap flag on m_axis_tuser
// and separated centres and forces on m_axis_tdata. A separate cfg channel
// (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the force magnitude; it
// is ready whenever reset is released and should be written only while the
// pipeline is empty.
// A request accepted on s_axis passes FRAC_BITS + 40 register stages before
// its result shows on m_axis: three front stages, one stage per root bit (32),
// a setup stage, one stage per quotient bit (FRAC_BITS + 1) and three back
// stages.
// Throughput is one request per cycle while m_axis_tready stays high. Each
// stage holds a valid bit and only stalls when it is full and the stage after
// it is stalled, so a stalled receiver lets the bubbles behind the output
// fill up before s_axis_tready drops; nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and restores the force
// magnitude to 100.0 in the chosen fixed point format. Coincident centres give
// zero forces and unchanged centres, and overlap unless both radii are zero.
`default_nettype none
`include "assert_macros.svh"
module circle_pair_collision_resolve_unit #(
    parameter int FRAC_BITS = cpcr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // tdata: first_center_x, first_center_y, first_radius, second_center_x,
    // second_center_y, second_radius, then two zero pad bits.
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [cpcr_pkg::IN_W-1:0]  s_axis_tdata,
    // tdata: new_first_x, new_first_y, new_second_x, new_second_y,
    // first_force_x, first_force_y, second_force_x, second_force_y.
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [cpcr_pkg::OUT_W-1:0]      m_axis_tdata,
    // tuser: overlap.
    output logic                            m_axis_tuser,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [30:0]                i_cfg_data
);
    import cpcr_pkg::*;

    localparam int W_N     = FRAC_BITS + 33;
    localparam int DIV_N   = FRAC_BITS + 1;
    localparam int S_SQRT  = 3;
    localparam int S_SETUP = S_SQRT + SQRT_STEPS;
    localparam int S_DIV   = S_SETUP + 1;
    localparam int S_BACK  = S_DIV + DIV_N;
    localparam int NS      = S_BACK + 3;
    localparam logic [30:0] FORCE_RST = 31'(longint'(FORCE_DEF) << FRAC_BITS);

    // Stage control: a stage loads whenever it is empty or the next one moves.
    logic [NS-1:0] r_vld;
    logic [NS:0]   rdy;
    logic [30:0]   r_force;

    assign rdy[NS] = m_axis_tready;
    for (genvar k = 0; k < NS; k++) begin : g_rdy
        assign rdy[k] = !r_vld[k] || rdy[k + 1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_force <= FORCE_RST;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k - 1];
                end
            end
            if (i_cfg_valid) begin
                r_force <= i_cfg_data;
            end
        end
    end

    // Neither request channel accepts anything while reset is held.
    assign s_axis_tready = rdy[0] && i_rst_n;
    assign o_cfg_ready   = i_rst_n;

    // Differences, squares and the exact overlap decision.
    t_pipe sq [0:SQRT_STEPS];

    cpcr_front u_front (
        .i_clk   (i_clk),
        .i_load  (rdy[2:0]),
        .i_tdata (s_axis_tdata),
        .o_q     (sq[0])
    );

    // Square root, one result bit per stage.
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        cpcr_sqrt_step #(.STEP(k)) u_step (
            .i_clk  (i_clk),
            .i_load (rdy[S_SQRT + k]),
            .i_d    (sq[k]),
            .o_q    (sq[k + 1])
        );
    end

    // Setup stage: distance, penetration depth and rounded dividends.
    t_pipe            dv   [0:DIV_N];
    logic [W_N-1:0]   remx [0:DIV_N];
    logic [W_N-1:0]   remy [0:DIV_N];
    logic [FRAC_BITS:0] qx [0:DIV_N];
    logic [FRAC_BITS:0] qy [0:DIV_N];
    t_pipe          r_set, n_set;
    logic [W_N-1:0] r_nx, r_ny;

    always_comb begin
        n_set       = sq[SQRT_STEPS];
        n_set.dlen  = sq[SQRT_STEPS].res[31:0];
        n_set.depth = sq[SQRT_STEPS].rsum - sq[SQRT_STEPS].res[31:0];
        n_set.dz    = (sq[SQRT_STEPS].res[31:0] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[S_SETUP]) begin
            r_set <= n_set;
            r_nx  <= {1'b0, n_set.adx, {FRAC_BITS{1'b0}}} + W_N'(n_set.dlen[31:1]);
            r_ny  <= {1'b0, n_set.ady, {FRAC_BITS{1'b0}}} + W_N'(n_set.dlen[31:1]);
        end
    end

    assign dv[0]   = r_set;
    assign remx[0] = r_nx;
    assign remy[0] = r_ny;
    assign qx[0]   = '0;
    assign qy[0]   = '0;

    // Direction components, one quotient bit per stage.
    for (genvar k = 0; k < DIV_N; k++) begin : g_div
        cpcr_div_step #(.FRAC_BITS(FRAC_BITS), .STEP(k)) u_step (
            .i_clk  (i_clk),
            .i_load (rdy[S_DIV + k]),
            .i_d    (dv[k]),
            .i_remx (remx[k]),
            .i_remy (remy[k]),
            .i_qx   (qx[k]),
            .i_qy   (qy[k]),
            .o_q    (dv[k + 1]),
            .o_remx (remx[k + 1]),
            .o_remy (remy[k + 1]),
            .o_qx   (qx[k + 1]),
            .o_qy   (qy[k + 1])
        );
    end

    // Products, rounding and the saturated output register.
    t_result res;

    cpcr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_load  (rdy[NS-1:S_BACK]),
        .i_d     (dv[DIV_N]),
        .i_qx    (qx[DIV_N]),
        .i_qy    (qy[DIV_N]),
        .i_force (r_force),
        .o_res   (res)
    );

    assign m_axis_tvalid = r_vld[NS-1];
    assign m_axis_tuser  = res.hit;
    assign m_axis_tdata  = {res.sfy, res.sfx, res.ffy, res.ffx,
                            res.nsy, res.nsx, res.nfy, res.nfx};

    `CPCR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `CPCR_ASSERT_NEXT(a_in_enters, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_vld[0])
    `CPCR_ASSERT_IMPLY(a_no_hit_no_force, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser,
        m_axis_tdata[255:128] == '0)
    `CPCR_ASSERT_IMPLY(a_force_balance, i_clk, i_rst_n, m_axis_tvalid,
        (m_axis_tdata[159:128] == 32'(-m_axis_tdata[223:192])) &&
        (m_axis_tdata[191:160] == 32'(-m_axis_tdata[255:224])))
endmodule
`default_nettype wire
